/* sv/bdac_pkg.sv */
// ----------------------------------------------------------------------------
// bdac_pkg: shared types and constants of the binary to decimal ASCII core
// Holds the word width, digit count, character codes and job/state types.
// ----------------------------------------------------------------------------
package bdac_pkg;

    localparam int VALUE_WIDTH = 64;
    // Decimal digits needed for the largest unsigned word.
    localparam int NUM_DIGITS  = 20;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam int DIG_W       = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W      = 6;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } t_back_state;

endpackage

/* sv/bdac_if.sv */
// ----------------------------------------------------------------------------
// bdac_if: stream channels of the binary to decimal ASCII core
// Input channel carries a word and its opcode, output channel one character.
// ----------------------------------------------------------------------------
interface bdac_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] value_bits;

    modport source (output valid, output opcode, output value_bits, input ready);
    modport sink   (input valid, input opcode, input value_bits, output ready);
endinterface

interface bdac_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* sv/bdac_front.sv */
// ----------------------------------------------------------------------------
// bdac_front: input stage
// Accepts a word, picks the sign and forms the unsigned magnitude.
// ----------------------------------------------------------------------------
module bdac_front (
    bdac_in_if.sink         i_in,
    input  logic            i_q_ready,
    output logic            o_q_valid,
    output bdac_pkg::t_job  o_q_job
);

    logic [bdac_pkg::VALUE_WIDTH-1:0] w_val;
    logic                             w_neg;

    assign w_val = i_in.value_bits[bdac_pkg::VALUE_WIDTH-1:0];
    assign w_neg = (i_in.opcode == bdac_pkg::OP_SIGNED) && w_val[bdac_pkg::VALUE_WIDTH-1];

    // The most negative value negates to itself, which read unsigned is exact.
    assign o_q_job.neg = w_neg;
    assign o_q_job.mag = w_neg ? (~w_val + 1'b1) : w_val;
    assign o_q_valid   = i_in.valid;
    assign i_in.ready  = i_q_ready;

endmodule

/* sv/bdac_queue.sv */
// ----------------------------------------------------------------------------
// bdac_queue: two-entry job queue
// Decouples the input stage from the conversion engine.
// ----------------------------------------------------------------------------
module bdac_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bdac_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bdac_pkg::t_job o_job
);

    bdac_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* sv/bdac_back.sv */
// ----------------------------------------------------------------------------
// bdac_back: conversion engine
// Double-dabble over the magnitude one bit a cycle, then emits the sign and
// the digits most significant first through a registered output beat.
// ----------------------------------------------------------------------------
module bdac_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  bdac_pkg::t_job  i_q_job,
    output logic            o_q_pop,
    bdac_out_if.source      o_out
);

    bdac_pkg::t_back_state r_state, n_state;

    logic [bdac_pkg::VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [bdac_pkg::BCD_W-1:0]       r_bcd, n_bcd;
    logic [bdac_pkg::STEP_W-1:0]      r_step, n_step;
    logic [bdac_pkg::DIG_W-1:0]       r_dig, n_dig;
    logic                             r_neg, n_neg;

    logic                             r_out_valid, n_out_valid;
    logic [bdac_pkg::CHAR_W-1:0]      r_out_char, n_out_char;
    logic                             r_out_last, n_out_last;

    logic [bdac_pkg::BCD_W-1:0]       w_adj;
    logic [3:0]                       w_top;
    logic                             w_slot_free;
    logic                             w_step_done;
    logic                             w_one_left;

    assign w_top       = r_bcd[bdac_pkg::BCD_W-1 -: 4];
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_step_done = (r_step == bdac_pkg::STEP_W'(bdac_pkg::VALUE_WIDTH - 1));
    assign w_one_left  = (r_dig == bdac_pkg::DIG_W'(1));

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < bdac_pkg::NUM_DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? (r_bcd[4*d +: 4] + 4'd3)
                                                         : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bdac_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = bdac_pkg::ST_CONV;
                end
            end
            bdac_pkg::ST_CONV: begin
                if (w_step_done) begin
                    n_state = r_neg ? bdac_pkg::ST_SIGN : bdac_pkg::ST_SKIP;
                end
            end
            bdac_pkg::ST_SIGN: begin
                if (w_slot_free) begin
                    n_state = bdac_pkg::ST_SKIP;
                end
            end
            bdac_pkg::ST_SKIP: begin
                if (w_top != 4'd0 || w_one_left) begin
                    n_state = bdac_pkg::ST_EMIT;
                end
            end
            bdac_pkg::ST_EMIT: begin
                if (w_slot_free && w_one_left) begin
                    n_state = bdac_pkg::ST_IDLE;
                end
            end
            default: n_state = bdac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_step      = r_step;
        n_dig       = r_dig;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        case (r_state)
            bdac_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_bin   = i_q_job.mag;
                    n_neg   = i_q_job.neg;
                    n_bcd   = '0;
                    n_step  = '0;
                    n_dig   = bdac_pkg::DIG_W'(bdac_pkg::NUM_DIGITS);
                end
            end
            bdac_pkg::ST_CONV: begin
                n_bcd  = {w_adj[bdac_pkg::BCD_W-2:0], r_bin[bdac_pkg::VALUE_WIDTH-1]};
                n_bin  = {r_bin[bdac_pkg::VALUE_WIDTH-2:0], 1'b0};
                n_step = r_step + 1'b1;
            end
            bdac_pkg::ST_SIGN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = bdac_pkg::CHAR_MINUS;
                    n_out_last  = 1'b0;
                end
            end
            bdac_pkg::ST_SKIP: begin
                // Leading zeros are dropped, but the units digit always stays.
                if (w_top == 4'd0 && !w_one_left) begin
                    n_bcd = {r_bcd[bdac_pkg::BCD_W-5:0], 4'd0};
                    n_dig = r_dig - 1'b1;
                end
            end
            bdac_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = bdac_pkg::CHAR_ZERO + {2'b00, w_top};
                    n_out_last  = w_one_left;
                    n_bcd       = {r_bcd[bdac_pkg::BCD_W-5:0], 4'd0};
                    n_dig       = r_dig - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdac_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_dig       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_dig       <= n_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last_char = r_out_last;

endmodule

/* sv/binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core: 64-bit word to decimal ASCII text
// i_in takes one beat per word: opcode (0 unsigned, 1 signed) and value_bits.
// o_out gives one beat per character, most significant digit first, with a
// leading '-' for negative signed words and last_char set on the final digit.
// A front stage classifies the word and forms its magnitude into a two-entry
// queue; the back engine takes a job from the queue when idle, runs one
// double-dabble shift per cycle over all 64 magnitude bits, emits a minus
// sign if needed, then steps through the 20 digit positions, dropping
// leading zeros without a beat and emitting one beat per remaining digit.
// The engine finishes one word before it takes the next from the queue.
// A stall on o_out holds the output register and pauses the engine while
// it has a sign or digit to emit; the queue keeps accepting up to two
// waiting words meanwhile.
// Reset empties the queue and the output register and idles the engine;
// no other clearing.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdac_in_if.sink     i_in,
    bdac_out_if.source  o_out
);

    logic           w_q_push;
    logic           w_q_full;
    logic           w_front_valid;
    bdac_pkg::t_job w_front_job;
    logic           w_q_pop;
    logic           w_q_valid;
    bdac_pkg::t_job w_q_job;

    assign w_q_push = w_front_valid && !w_q_full;

    bdac_front u_front (
        .i_in      (i_in),
        .i_q_ready (!w_q_full),
        .o_q_valid (w_front_valid),
        .o_q_job   (w_front_job)
    );

    bdac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    bdac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

endmodule

/* dv/bdac_text_checker.sv */
// ----------------------------------------------------------------------------
// bdac_text_checker: decimal text predictor and scoreboard
// Watches the word and character channels of the binary to decimal ASCII
// core, predicts the text of every accepted word, and compares each
// character beat field by field against the oldest expected character.
// ----------------------------------------------------------------------------
module bdac_text_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bdac_in_if     i_in,
    bdac_out_if    i_out,
    output int     o_fail_count,
    output int     o_pending_chars
);

    typedef struct packed {
        logic [bdac_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_char_beat;

    t_char_beat expected_chars_q[$];
    int         mismatches = 0;

    // Appends the characters of one word's decimal text, sign first.
    function automatic void predict_decimal_text(input logic op, input logic [63:0] word);
        logic [bdac_pkg::VALUE_WIDTH-1:0] v;
        logic [bdac_pkg::VALUE_WIDTH-1:0] mag;
        logic                             negative;
        logic [3:0]                       digit_q[$];
        t_char_beat                       beat;
        v        = word[bdac_pkg::VALUE_WIDTH-1:0];
        negative = (op == bdac_pkg::OP_SIGNED) && v[bdac_pkg::VALUE_WIDTH-1];
        // Taken as unsigned, so the most negative value has an exact magnitude.
        mag      = negative ? (~v + 1'b1) : v;
        do begin
            digit_q.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (negative) begin
            beat.code = bdac_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars_q.push_back(beat);
        end
        foreach (digit_q[i]) begin
            beat.code = bdac_pkg::CHAR_ZERO + bdac_pkg::CHAR_W'(digit_q[i]);
            beat.last = (i == digit_q.size() - 1);
            expected_chars_q.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_char_beat want;
        if (!i_rst_n) begin
            o_fail_count    <= 0;
            o_pending_chars <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                predict_decimal_text(i_in.opcode, i_in.value_bits);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_chars_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat: expected none, got code %0d last %0d",
                             $time, i_out.char_code, i_out.last_char);
                end else begin
                    want = expected_chars_q.pop_front();
                    if (i_out.char_code !== want.code) begin
                        mismatches++;
                        $display("%0t: char_code mismatch: expected %0d, got %0d",
                                 $time, want.code, i_out.char_code);
                    end
                    if (i_out.last_char !== want.last) begin
                        mismatches++;
                        $display("%0t: last_char mismatch: expected %0d, got %0d",
                                 $time, want.last, i_out.last_char);
                    end
                end
            end
            o_fail_count    <= mismatches;
            o_pending_chars <= expected_chars_q.size();
        end
    end

endmodule

/* dv/tb_binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_core: testbench of the binary to decimal core
// Sends directed extremes and random words in both readings with random
// gaps on both channels, a long output hold-off and full-rate stretches.
// A separate checker predicts every character; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;

    localparam int WORD_LATENCY = 90;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LIMIT  = 4000;

    logic clk;
    logic rst_n;
    bit   rx_hold_req  = 1'b0;
    bit   rx_full_rate = 1'b0;
    int   fail_count;
    int   pending_chars;

    bdac_in_if  in_if ();
    bdac_out_if out_if ();

    binary_to_decimal_ascii_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    bdac_text_checker text_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in            (in_if),
        .i_out           (out_if),
        .o_fail_count    (fail_count),
        .o_pending_chars (pending_chars)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic pick_opcode();
        return ($urandom_range(0, 1) == 1) ? bdac_pkg::OP_SIGNED : bdac_pkg::OP_UNSIGNED;
    endfunction

    // Mix of full-width words, short magnitudes of either sign, values next
    // to powers of ten and the range extremes.
    function automatic logic [63:0] random_word();
        logic [63:0] raw;
        logic [63:0] ten_pow;
        int          roll;
        int          bits;
        raw     = {$urandom, $urandom};
        roll    = $urandom_range(0, 99);
        bits    = $urandom_range(1, 64);
        ten_pow = 64'd1;
        if (roll < 30) return raw;
        if (roll < 60) return raw >> (64 - bits);
        if (roll < 75) return ~(raw >> (64 - bits)) + 64'd1;
        if (roll < 85) begin
            repeat ($urandom_range(0, 19)) ten_pow = ten_pow * 64'd10;
            return ten_pow + 64'($urandom_range(0, 2)) - 64'd1;
        end
        if (roll < 90) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return {1'b1, 63'd0};
                default: return {1'b0, {63{1'b1}}};
            endcase
        end
        return {32'd0, raw[31:0]};
    endfunction

    task automatic offer_word(input logic op, input logic [63:0] word, input bit with_gaps);
        int gap;
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.value_bits <= word;
        do @(posedge clk); while (!in_if.ready);
        gap = with_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender until every predicted character has been seen.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0) @(posedge clk);
    endtask

    initial begin : char_sink
        int span;
        forever begin
            if (rx_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end else if (rx_full_rate) begin
                out_if.ready <= 1'b1;
                @(posedge clk);
            end else begin
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 8);
                out_if.ready <= 1'b1;
                repeat (span) @(posedge clk);
                span = pick_gap();
                if (span > 40) span = 40;
                if (span > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : word_source
        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.opcode     <= bdac_pkg::OP_UNSIGNED;
        in_if.value_bits <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in both readings, digit-count boundaries and range extremes.
        offer_word(bdac_pkg::OP_UNSIGNED, 64'd0, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   64'd0, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, 64'd1, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, 64'd9, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, 64'd10, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   64'd99, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   64'd100, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   64'd12345, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, '1, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   '1, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   {1'b1, 63'd0}, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, {1'b1, 63'd0}, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   {1'b0, {63{1'b1}}}, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, {1'b0, {63{1'b1}}}, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   {1'b1, 62'd0, 1'b1}, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   ~64'd10 + 64'd1, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, ~64'd10 + 64'd1, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, 64'd10000000000000000000, 1'b1);
        offer_word(bdac_pkg::OP_UNSIGNED, 64'd9999999999999999999, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   64'h5555_5555_5555_5555, 1'b1);
        offer_word(bdac_pkg::OP_SIGNED,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        wait_for_drain();

        repeat (140) offer_word(pick_opcode(), random_word(), 1'b1);

        // Long output hold-off while words keep coming, so the input stalls.
        rx_hold_req = 1'b1;
        repeat (10) offer_word(pick_opcode(), random_word(), 1'b0);
        wait_for_drain();

        rx_full_rate = 1'b1;
        repeat (80) offer_word(pick_opcode(), random_word(), 1'b0);
        wait_for_drain();
        rx_full_rate = 1'b0;

        repeat (190) offer_word(pick_opcode(), random_word(), 1'b1);
        wait_for_drain();
        repeat (2 * WORD_LATENCY) @(posedge clk);

        if (fail_count == 0 && pending_chars == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
